/* design/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants
// Cull codes, per-item control bundle and register map of the projector.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int FOCAL_BITS = 24;
  localparam int DIM_BITS   = 13;
  // quotient bits of the projection divide; a kept point has |offset| <= w/2
  localparam int QUO_BITS   = 13;

  typedef enum logic [2:0] {
    CULL_NONE  = 3'd0,
    CULL_X_NEG = 3'd1,
    CULL_X_POS = 3'd2,
    CULL_Y_POS = 3'd3,
    CULL_Y_NEG = 3'd4,
    CULL_NEAR  = 3'd5
  } cull_t;

  typedef enum logic [1:0] {
    REG_FOCAL  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic  visible;
    cull_t reason;
    logic  neg_x;
    logic  neg_y;
    logic  zero_z;
  } meta_t;

endpackage

/* design/point_frustum_cull_project.sv */
// ----------------------------------------------------------------------------
// point_frustum_cull_project: perspective projection with frustum culling
// Culls camera-frame points against the view frustum and projects survivors.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   input    | in_valid/in_ready, in_point_x/y/z      | in
//   result   | out_valid/out_ready, out_visible,      | out
//            | out_cull_reason, out_pixel_x/y         |
//   config   | psel/penable/pwrite/paddr/pwdata/...   | in/out
//
// One item enters per cycle unless a result is stalled; every item passes
// 2 product and test stages, QUO_BITS = 13 divide cells and 1 placement
// stage. The divide chain settles one quotient bit per cell.
// A stall on out_ready freezes the whole chain; in_ready follows out_ready
// whenever a result waits. rst_n (synchronous) clears every valid bit and
// loads focal length 100.0, width 800, height 600.
//
module point_frustum_cull_project #(
  parameter int COORD_BITS = 24,
  parameter int PIXEL_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_BITS-1:0]  in_point_x,
  input  logic [COORD_BITS-1:0]  in_point_y,
  input  logic [COORD_BITS-1:0]  in_point_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_visible,
  output logic [2:0]             out_cull_reason,
  output logic [PIXEL_BITS-1:0]  out_pixel_x,
  output logic [PIXEL_BITS-1:0]  out_pixel_y,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int NW = COORD_BITS + 25;
  localparam int DW = COORD_BITS + 8;
  localparam int QB = pfc_pkg::QUO_BITS;

  // ---- configuration registers ----
  logic [pfc_pkg::FOCAL_BITS-1:0] focal_r;
  logic [pfc_pkg::DIM_BITS-1:0]   width_r, height_r;
  pfc_pkg::reg_idx_t              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = pfc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= pfc_pkg::FOCAL_BITS'(25600);
      width_r  <= pfc_pkg::DIM_BITS'(800);
      height_r <= pfc_pkg::DIM_BITS'(600);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        pfc_pkg::REG_FOCAL:  focal_r  <= pwdata[pfc_pkg::FOCAL_BITS-1:0];
        pfc_pkg::REG_WIDTH:  width_r  <= pwdata[pfc_pkg::DIM_BITS-1:0];
        pfc_pkg::REG_HEIGHT: height_r <= pwdata[pfc_pkg::DIM_BITS-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pfc_pkg::REG_FOCAL:  prdata = 32'(focal_r);
      pfc_pkg::REG_WIDTH:  prdata = 32'(width_r);
      pfc_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:             prdata = '0;
    endcase
  end

  // ---- global advance: hold everything while a result waits ----
  logic adv;
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // ---- front: products and cull tests ----
  logic           vld_c  [0:QB];
  pfc_pkg::meta_t meta_c [0:QB];
  logic [DW-1:0]  d_c    [0:QB];
  logic [NW-1:0]  rx_c   [0:QB];
  logic [NW-1:0]  ry_c   [0:QB];
  logic [QB-1:0]  qx_c   [0:QB];
  logic [QB-1:0]  qy_c   [0:QB];

  pfc_front #(.CB(COORD_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (in_valid),
    .x_i    ($signed(in_point_x)),
    .y_i    ($signed(in_point_y)),
    .z_i    ($signed(in_point_z)),
    .f_i    (focal_r),
    .w_i    (width_r),
    .h_i    (height_r),
    .vld_o  (vld_c[0]),
    .meta_o (meta_c[0]),
    .d_o    (d_c[0]),
    .nx_o   (rx_c[0]),
    .ny_o   (ry_c[0])
  );

  assign qx_c[0] = '0;
  assign qy_c[0] = '0;

  // ---- divide chain: most significant quotient bit first ----
  for (genvar k = 0; k < QB; k++) begin : g_cell
    pfc_div_cell #(.CB(COORD_BITS), .SHIFT(QB - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (vld_c[k]),
      .meta_i (meta_c[k]),
      .d_i    (d_c[k]),
      .rx_i   (rx_c[k]),
      .ry_i   (ry_c[k]),
      .qx_i   (qx_c[k]),
      .qy_i   (qy_c[k]),
      .vld_o  (vld_c[k+1]),
      .meta_o (meta_c[k+1]),
      .d_o    (d_c[k+1]),
      .rx_o   (rx_c[k+1]),
      .ry_o   (ry_c[k+1]),
      .qx_o   (qx_c[k+1]),
      .qy_o   (qy_c[k+1])
    );
  end

  // ---- back: floor, center, clamp; doubles as the output register ----
  pfc_back #(.CB(COORD_BITS), .PB(PIXEL_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .vld_i     (vld_c[QB]),
    .meta_i    (meta_c[QB]),
    .rx_i      (rx_c[QB]),
    .ry_i      (ry_c[QB]),
    .qx_i      (qx_c[QB]),
    .qy_i      (qy_c[QB]),
    .w_i       (width_r),
    .h_i       (height_r),
    .vld_o     (out_valid),
    .visible_o (out_visible),
    .reason_o  (out_cull_reason),
    .px_o      (out_pixel_x),
    .py_o      (out_pixel_y)
  );

endmodule

/* design/pfc_front.sv */
// ----------------------------------------------------------------------------
// pfc_front: products and cull tests
// Two stages: form x*f, y*f, hw*z, hh*z; then compare and set up the divide.
// ----------------------------------------------------------------------------
module pfc_front #(
  parameter int CB = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               vld_i,
  input  logic signed [CB-1:0]               x_i,
  input  logic signed [CB-1:0]               y_i,
  input  logic signed [CB-1:0]               z_i,
  input  logic [pfc_pkg::FOCAL_BITS-1:0]     f_i,
  input  logic [pfc_pkg::DIM_BITS-1:0]       w_i,
  input  logic [pfc_pkg::DIM_BITS-1:0]       h_i,
  output logic                               vld_o,
  output pfc_pkg::meta_t                     meta_o,
  output logic [CB+7:0]                      d_o,
  output logic [CB+24:0]                     nx_o,
  output logic [CB+24:0]                     ny_o
);

  localparam int PW = CB + pfc_pkg::FOCAL_BITS + 1;
  localparam int BW = CB + pfc_pkg::DIM_BITS;
  localparam int MW = CB + pfc_pkg::FOCAL_BITS + 2;

  logic signed [PW-1:0] xf_r, yf_r;
  logic signed [BW-1:0] bw_r, bh_r;
  logic signed [CB-1:0] z_r;
  logic                 vld_a_r;

  logic signed [pfc_pkg::FOCAL_BITS:0] f_s;
  logic signed [pfc_pkg::DIM_BITS-1:0] hw_s, hh_s;

  assign f_s  = $signed({1'b0, f_i});
  assign hw_s = $signed({1'b0, w_i[pfc_pkg::DIM_BITS-1:1]});
  assign hh_s = $signed({1'b0, h_i[pfc_pkg::DIM_BITS-1:1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xf_r <= PW'(x_i * f_s);
      yf_r <= PW'(y_i * f_s);
      bw_r <= BW'(z_i * hw_s);
      bh_r <= BW'(z_i * hh_s);
      z_r  <= z_i;
    end
  end

  logic signed [MW-1:0] xf_e, yf_e, bw_e, bh_e, z_e, f_e;
  pfc_pkg::cull_t       reason;
  pfc_pkg::meta_t       meta_nxt;

  always_comb begin
    xf_e = MW'(xf_r);
    yf_e = MW'(yf_r);
    bw_e = MW'(bw_r) <<< 8;
    bh_e = MW'(bh_r) <<< 8;
    z_e  = MW'(z_r);
    f_e  = $signed(MW'(f_i));
    if (xf_e < -bw_e)      reason = pfc_pkg::CULL_X_NEG;
    else if (xf_e > bw_e)  reason = pfc_pkg::CULL_X_POS;
    else if (yf_e > bh_e)  reason = pfc_pkg::CULL_Y_POS;
    else if (yf_e < -bh_e) reason = pfc_pkg::CULL_Y_NEG;
    else if (z_e < f_e)    reason = pfc_pkg::CULL_NEAR;
    else                   reason = pfc_pkg::CULL_NONE;
    meta_nxt.visible = (reason == pfc_pkg::CULL_NONE);
    meta_nxt.reason  = reason;
    meta_nxt.neg_x   = xf_r[PW-1];
    meta_nxt.neg_y   = yf_r[PW-1];
    meta_nxt.zero_z  = (z_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_o <= meta_nxt;
      d_o    <= {z_r, 8'd0};
      nx_o   <= xf_r[PW-1] ? $unsigned(-xf_r) : $unsigned(xf_r);
      ny_o   <= yf_r[PW-1] ? $unsigned(-yf_r) : $unsigned(yf_r);
    end
  end

endmodule

/* design/pfc_div_cell.sv */
// ----------------------------------------------------------------------------
// pfc_div_cell: one restoring-divide cell
// Settle one quotient bit for both coordinates and pass the item on.
// ----------------------------------------------------------------------------
module pfc_div_cell #(
  parameter int CB    = 24,
  parameter int SHIFT = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  pfc_pkg::meta_t                    meta_i,
  input  logic [CB+7:0]                     d_i,
  input  logic [CB+24:0]                    rx_i,
  input  logic [CB+24:0]                    ry_i,
  input  logic [pfc_pkg::QUO_BITS-1:0]      qx_i,
  input  logic [pfc_pkg::QUO_BITS-1:0]      qy_i,
  output logic                              vld_o,
  output pfc_pkg::meta_t                    meta_o,
  output logic [CB+7:0]                     d_o,
  output logic [CB+24:0]                    rx_o,
  output logic [CB+24:0]                    ry_o,
  output logic [pfc_pkg::QUO_BITS-1:0]      qx_o,
  output logic [pfc_pkg::QUO_BITS-1:0]      qy_o
);

  localparam int NW = CB + 25;
  localparam int EW = NW + pfc_pkg::QUO_BITS;

  logic [EW-1:0] dsh;
  logic          ge_x, ge_y;

  always_comb begin
    dsh  = EW'(d_i) << SHIFT;
    ge_x = (EW'(rx_i) >= dsh);
    ge_y = (EW'(ry_i) >= dsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_o <= meta_i;
      d_o    <= d_i;
      rx_o   <= ge_x ? NW'(EW'(rx_i) - dsh) : rx_i;
      ry_o   <= ge_y ? NW'(EW'(ry_i) - dsh) : ry_i;
      qx_o   <= qx_i | (pfc_pkg::QUO_BITS'(ge_x) << SHIFT);
      qy_o   <= qy_i | (pfc_pkg::QUO_BITS'(ge_y) << SHIFT);
    end
  end

endmodule

/* design/pfc_back.sv */
// ----------------------------------------------------------------------------
// pfc_back: pixel placement and result register
// Floor-correct the quotient, add the half dimension, clamp to the picture.
// ----------------------------------------------------------------------------
module pfc_back #(
  parameter int CB = 24,
  parameter int PB = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  pfc_pkg::meta_t                    meta_i,
  input  logic [CB+24:0]                    rx_i,
  input  logic [CB+24:0]                    ry_i,
  input  logic [pfc_pkg::QUO_BITS-1:0]      qx_i,
  input  logic [pfc_pkg::QUO_BITS-1:0]      qy_i,
  input  logic [pfc_pkg::DIM_BITS-1:0]      w_i,
  input  logic [pfc_pkg::DIM_BITS-1:0]      h_i,
  output logic                              vld_o,
  output logic                              visible_o,
  output logic [2:0]                        reason_o,
  output logic [PB-1:0]                     px_o,
  output logic [PB-1:0]                     py_o
);

  localparam int SW = 20;

  function automatic logic [PB-1:0] place(
    input logic                            neg,
    input logic                            zero,
    input logic                            rnz,
    input logic [pfc_pkg::QUO_BITS-1:0]    q,
    input logic [pfc_pkg::DIM_BITS-1:0]    dim
  );
    logic signed [SW-1:0] off, pos, lim, pmax;
    begin
      off  = $signed(SW'(q));
      if (neg) off = -(off + $signed(SW'(rnz)));
      if (zero) off = '0;
      pos  = off + $signed(SW'(dim[pfc_pkg::DIM_BITS-1:1]));
      lim  = (dim == '0) ? '0 : $signed(SW'(dim) - SW'(1));
      pmax = $signed((SW'(1) << PB) - SW'(1));
      if (lim > pmax) lim = pmax;
      if (pos < 0) pos = '0;
      if (pos > lim) pos = lim;
      place = pos[PB-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible_o <= meta_i.visible;
      reason_o  <= meta_i.reason;
      if (meta_i.visible) begin
        px_o <= place(meta_i.neg_x, meta_i.zero_z, (rx_i != '0), qx_i, w_i);
        py_o <= place(meta_i.neg_y, meta_i.zero_z, (ry_i != '0), qy_i, h_i);
      end else begin
        px_o <= '0;
        py_o <= '0;
      end
    end
  end

endmodule

/* design/pfc_checker.sv */
// ----------------------------------------------------------------------------
// pfc_checker: port-level checks for the projector
// Watches the result channel and its relation to the input channel.
// ----------------------------------------------------------------------------
module pfc_checker #(
  parameter int COORD_BITS = 24,
  parameter int PIXEL_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_visible,
  input logic [2:0]            out_cull_reason,
  input logic [PIXEL_BITS-1:0] out_pixel_x,
  input logic [PIXEL_BITS-1:0] out_pixel_y
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cull_reason)
      && $stable(out_pixel_x) && $stable(out_pixel_y))
    else $error("result changed while stalled");

  a_kept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_cull_reason == pfc_pkg::CULL_NONE)
    else $error("kept item carries a cull code");

  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_cull_reason != pfc_pkg::CULL_NONE
      && out_cull_reason <= pfc_pkg::CULL_NEAR && out_pixel_x == '0 && out_pixel_y == '0)
    else $error("culled item malformed");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind point_frustum_cull_project pfc_checker #(
  .COORD_BITS(COORD_BITS),
  .PIXEL_BITS(PIXEL_BITS)
) u_pfc_checker (.*);
